// ===== hw/rtl/ihex_pkg.sv =====
package ihex_pkg;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_MARK  = 3'd1;
  localparam logic [2:0] ERR_EARLY_EOL = 3'd2;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd3;
  localparam logic [2:0] ERR_EARLY_EOF = 3'd4;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd5;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd6;
  localparam logic [2:0] ERR_JUNK_EOL  = 3'd7;

  localparam logic [7:0] REC_DATA      = 8'd0;
  localparam logic [7:0] REC_EOF       = 8'd1;
  localparam logic [7:0] REC_EXT_SEG   = 8'd2;
  localparam logic [7:0] REC_START_SEG = 8'd3;
  localparam logic [7:0] REC_EXT_LIN   = 8'd4;
  localparam logic [7:0] REC_START_LIN = 8'd5;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int unsigned RES_W = 144;

  // Packed from the lowest bit up: address, data_byte, error_code,
  // start_address, first_address, last_address, zero padding.
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] last_address;
    logic [31:0] first_address;
    logic [31:0] start_address;
    logic [2:0]  error_code;
    logic [7:0]  data_byte;
    logic [31:0] address;
  } ihex_result_t;

endpackage

// ===== hw/rtl/intel_hex_record_parser_top.sv =====
// An accepted character is first held in the input register; any result that it
// produces is then registered in the result register and offered on the result side.
// Throughput: one character per cycle while the result side keeps tready high.
// Reset (rst_ni low, asynchronous): parser waits for a record mark, linear
// addressing, lowest address all ones, no pending result.
module intel_hex_record_parser_top import ihex_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // char_code
  input  logic             s_axis_tlast,   // end_of_stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [RES_W-1:0] m_axis_tdata,   // address, data_byte, error_code, start_address,
                                           // first_address, last_address, zero pad
  output logic [1:0]       m_axis_tuser    // kind
);

  localparam logic [4:0] PH_MARK    = 5'd0;
  localparam logic [4:0] PH_EOL     = 5'd1;
  localparam logic [4:0] PH_DEAD    = 5'd2;
  localparam logic [4:0] PH_LEN     = 5'd4;
  localparam logic [4:0] PH_OFFH    = 5'd6;
  localparam logic [4:0] PH_OFFL    = 5'd8;
  localparam logic [4:0] PH_TYPE    = 5'd10;
  localparam logic [4:0] PH_PAYLOAD = 5'd12;
  localparam logic [4:0] PH_CSUM    = 5'd14;

  logic        in_vld_q;
  logic [7:0]  in_char_q;
  logic        in_eos_q;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] offset_q, offset_d;
  logic [2:0]  rkind_q, rkind_d;
  logic [7:0]  sum_q, sum_d;
  logic [1:0]  fpos_q, fpos_d;
  logic [7:0]  dpos_q, dpos_d;
  logic        linear_q, linear_d;
  logic [31:0] base_q, base_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] lowest_q, lowest_d;
  logic [31:0] highest_q, highest_d;
  logic [2:0]  fault_q, fault_d;

  logic         out_vld_q;
  logic [1:0]   out_kind_q;
  ihex_result_t out_res_q;

  logic         go;
  logic         res_vld;
  logic [1:0]   res_kind;
  ihex_result_t res;

  logic        is_eol;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [7:0]  byte_val;
  logic [7:0]  sum_new;
  logic [7:0]  dpos_inc;
  logic [31:0] addr;
  logic [2:0]  rep_code;

  assign go            = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || go;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = out_res_q;

  always_comb begin
    is_eol  = (in_char_q == CHAR_CR) || (in_char_q == CHAR_LF);
    is_hex  = 1'b0;
    hex_val = in_char_q[3:0];
    if (in_char_q inside {[8'h30:8'h39]}) begin
      is_hex = 1'b1;
    end else if (in_char_q inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      is_hex  = 1'b1;
      hex_val = in_char_q[3:0] + 4'd9;
    end
    byte_val = {nib_q, hex_val};
    sum_new  = sum_q + byte_val;
    dpos_inc = dpos_q + 8'd1;
    if (linear_q) begin
      addr = base_q + {16'd0, offset_q} + {24'd0, dpos_q};
    end else begin
      addr = {16'd0, offset_q + {8'd0, dpos_q}} + base_q;
    end
    if (phase_q == PH_DEAD) begin
      rep_code = fault_q;
    end else if (phase_q == PH_MARK || phase_q == PH_EOL) begin
      rep_code = ERR_NONE;
    end else begin
      rep_code = ERR_EARLY_EOF;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    len_d     = len_q;
    offset_d  = offset_q;
    rkind_d   = rkind_q;
    sum_d     = sum_q;
    fpos_d    = fpos_q;
    dpos_d    = dpos_q;
    linear_d  = linear_q;
    base_d    = base_q;
    entry_d   = entry_q;
    lowest_d  = lowest_q;
    highest_d = highest_q;
    fault_d   = fault_q;
    res_vld   = 1'b0;
    res_kind  = KIND_DATA;
    res       = '0;

    if (go) begin
      if (in_eos_q) begin
        res_vld        = 1'b1;
        res_kind       = KIND_REPORT;
        res.error_code = rep_code;
        if (rep_code == ERR_NONE) begin
          res.start_address = entry_q;
          res.first_address = lowest_q;
          res.last_address  = highest_q;
        end
        phase_d   = PH_MARK;
        nib_d     = '0;
        len_d     = '0;
        offset_d  = '0;
        rkind_d   = '0;
        sum_d     = '0;
        fpos_d    = '0;
        dpos_d    = '0;
        linear_d  = 1'b1;
        base_d    = '0;
        entry_d   = '0;
        lowest_d  = '1;
        highest_d = '0;
        fault_d   = ERR_NONE;
      end else if (phase_q == PH_DEAD) begin
        phase_d = PH_DEAD;
      end else if (phase_q == PH_MARK) begin
        if (in_char_q == CHAR_COLON) begin
          len_d    = '0;
          offset_d = '0;
          sum_d    = '0;
          phase_d  = PH_LEN;
        end else if (!is_eol) begin
          fault_d = ERR_BAD_MARK;
        end
      end else if (phase_q == PH_EOL) begin
        if (is_eol) begin
          phase_d = PH_MARK;
        end else begin
          fault_d = ERR_JUNK_EOL;
        end
      end else if (is_eol) begin
        fault_d = ERR_EARLY_EOL;
      end else if (!is_hex) begin
        fault_d = ERR_BAD_CHAR;
      end else if (!phase_q[0]) begin
        nib_d   = hex_val;
        phase_d = phase_q + 5'd1;
      end else begin
        phase_d = phase_q - 5'd1;
        sum_d   = sum_new;
        case (phase_q - 5'd1)
          PH_LEN: begin
            len_d   = byte_val;
            phase_d = PH_OFFH;
          end
          PH_OFFH: begin
            offset_d = {byte_val, 8'd0};
            phase_d  = PH_OFFL;
          end
          PH_OFFL: begin
            offset_d = {offset_q[15:8], byte_val};
            phase_d  = PH_TYPE;
          end
          PH_TYPE: begin
            if (byte_val > REC_START_LIN) begin
              fault_d = ERR_BAD_TYPE;
            end else begin
              rkind_d = byte_val[2:0];
              fpos_d  = '0;
              dpos_d  = '0;
              if (byte_val == REC_EOF || (byte_val == REC_DATA && len_q == 8'd0)) begin
                phase_d = PH_CSUM;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            fpos_d = fpos_q + 2'd1;
            case (rkind_q)
              REC_DATA[2:0]: begin
                if (addr < lowest_q) lowest_d = addr;
                if (addr > highest_q) highest_d = addr;
                dpos_d = dpos_inc;
                fpos_d = fpos_q;
                if (dpos_inc == len_q) phase_d = PH_CSUM;
                res_vld       = 1'b1;
                res_kind      = KIND_DATA;
                res.address   = addr;
                res.data_byte = byte_val;
              end
              REC_EXT_SEG[2:0]: begin
                if (fpos_q == 2'd0) begin
                  base_d = {12'd0, byte_val, 12'd0};
                end else begin
                  base_d   = base_q | {20'd0, byte_val, 4'd0};
                  linear_d = 1'b0;
                  phase_d  = PH_CSUM;
                end
              end
              REC_EXT_LIN[2:0]: begin
                if (fpos_q == 2'd0) begin
                  base_d = {byte_val, 24'd0};
                end else begin
                  base_d   = {base_q[31:24] | 8'd0, byte_val | base_q[23:16], 16'd0};
                  linear_d = 1'b1;
                  phase_d  = PH_CSUM;
                end
              end
              default: begin
                if (fpos_q == 2'd0) begin
                  entry_d = {24'd0, byte_val};
                end else begin
                  entry_d = {entry_q[23:0], byte_val};
                end
                if (fpos_q == 2'd3) phase_d = PH_CSUM;
              end
            endcase
          end
          default: begin
            if (sum_new != 8'd0) begin
              fault_d = ERR_CHECKSUM;
            end else begin
              phase_d = PH_EOL;
            end
          end
        endcase
      end

      if (!in_eos_q && fault_d != fault_q) begin
        phase_d        = PH_DEAD;
        res_vld        = 1'b1;
        res_kind       = KIND_ERROR;
        res            = '0;
        res.error_code = fault_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MARK;
      nib_q     <= '0;
      len_q     <= '0;
      offset_q  <= '0;
      rkind_q   <= '0;
      sum_q     <= '0;
      fpos_q    <= '0;
      dpos_q    <= '0;
      linear_q  <= 1'b1;
      base_q    <= '0;
      entry_q   <= '0;
      lowest_q  <= '1;
      highest_q <= '0;
      fault_q   <= ERR_NONE;
    end else begin
      phase_q   <= phase_d;
      nib_q     <= nib_d;
      len_q     <= len_d;
      offset_q  <= offset_d;
      rkind_q   <= rkind_d;
      sum_q     <= sum_d;
      fpos_q    <= fpos_d;
      dpos_q    <= dpos_d;
      linear_q  <= linear_d;
      base_q    <= base_d;
      entry_q   <= entry_d;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
      fault_q   <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res_vld) begin
      out_kind_q <= res_kind;
      out_res_q  <= res;
    end
  end

endmodule

// ===== hw/rtl/ihex_sva.sv =====
module ihex_sva import ihex_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  ihex_result_t res;
  assign res = m_axis_tdata;

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DATA |->
      res.error_code == ERR_NONE && res.start_address == '0 &&
      res.first_address == '0 && res.last_address == '0)
    else $error("data write carries report fields");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
      res.error_code != ERR_NONE && res.address == '0 && res.data_byte == '0)
    else $error("error transaction without code");

  a_bad_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_REPORT && res.error_code != ERR_NONE |->
      res.start_address == '0 && res.first_address == '0 && res.last_address == '0)
    else $error("failed report carries addresses");

endmodule

bind intel_hex_record_parser_top ihex_sva u_ihex_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
